// ----- design/sorted_id_dedup_latest_macros.svh -----
// Assertion macros for the sorted id dedup block.
// Included by the top level; needs no other file.
`ifndef SORTED_ID_DEDUP_LATEST_MACROS_SVH
`define SORTED_ID_DEDUP_LATEST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIDL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIDL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/sidl_pkg.sv -----
// Shared types and constants for the sorted id dedup block.
// No dependencies; used by sidl_out_queue, sorted_id_dedup_latest and sidl_dedup_monitor.
`default_nettype none

package sidl_pkg;

   localparam int SIDL_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic        has_item;
      logic [31:0] out_id;
      logic [31:0] out_stamp;
      logic [63:0] out_payload;
      logic        list_end;
   } rsp_type;

   // Up to two results per request, in order: first, then second.
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic room_for_two;
   } qstat_type;

endpackage

`default_nettype wire

// ----- design/sorted_id_dedup_latest.sv -----
// Sorted id dedup: keeps the newest entry of each run of equal document ids.
//
// Requests (req_*) carry one index entry each; entries with equal req_doc_id
// arrive adjacent. A request is taken on a clock edge with req_valid high and
// req_stall low. Results (rsp_*) leave the same way under rsp_valid/rsp_stall.
// A request yields no result (same run, or an invalid run closed), one result
// (valid run closed, or list end) or two (valid run closed by an entry marked
// last: the old run, then the end). The end result has rsp_list_end high;
// rsp_has_item low there means the final run was marked invalid and all item
// fields read zero. A result is queued when its request is taken and is
// offered after those ahead of it. Throughput: one request per cycle while
// results are drained at the same pace; a request with two results takes two
// queue slots. The output side is a small result queue, so a stalled receiver
// does not hold up requests until the queue has less than two free slots;
// req_stall then rises and stays high until the receiver drains it.
// Reset (synchronous): drops the held entry and empties the result queue.
`default_nettype none
`include "sorted_id_dedup_latest_macros.svh"

module sorted_id_dedup_latest #(
   parameter int QUEUE_DEPTH = sidl_pkg::SIDL_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_doc_id,
   input  wire logic [31:0] req_stamp,
   input  wire logic        req_is_invalid,
   input  wire logic [63:0] req_payload,
   input  wire logic        req_last_of_list,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_has_item,
   output logic [31:0]      rsp_out_id,
   output logic [31:0]      rsp_out_stamp,
   output logic [63:0]      rsp_out_payload,
   output logic             rsp_list_end
);
   import sidl_pkg::*;

   logic        held_valid_ff, held_valid_in;
   logic [31:0] held_id_ff, held_id_in;
   logic [31:0] held_stamp_ff, held_stamp_in;
   logic        held_invalid_ff, held_invalid_in;
   logic [63:0] held_payload_ff, held_payload_in;

   logic      accept;
   logic      id_differs;
   logic      take_new;
   logic      emit_prev;
   rsp_type   prev_rsp;
   rsp_type   end_rsp;
   push_type  push;
   rsp_type   head;
   qstat_type stat;
   logic      pop;

   assign accept     = req_valid && !req_stall;
   assign id_differs = held_valid_ff && (req_doc_id != held_id_ff);
   // New run, or a strictly newer stamp within the run; ties keep the held one.
   assign take_new   = !held_valid_ff || id_differs || (held_stamp_ff < req_stamp);
   assign emit_prev  = id_differs && !held_invalid_ff;

   always_comb begin
      held_id_in      = take_new ? req_doc_id     : held_id_ff;
      held_stamp_in   = take_new ? req_stamp      : held_stamp_ff;
      held_invalid_in = take_new ? req_is_invalid : held_invalid_ff;
      held_payload_in = take_new ? req_payload    : held_payload_ff;
      held_valid_in   = !req_last_of_list;

      prev_rsp.has_item    = 1'b1;
      prev_rsp.out_id      = held_id_ff;
      prev_rsp.out_stamp   = held_stamp_ff;
      prev_rsp.out_payload = held_payload_ff;
      prev_rsp.list_end    = 1'b0;

      // End of list: the entry kept after this request, or an empty marker.
      end_rsp.has_item    = !held_invalid_in;
      end_rsp.out_id      = held_invalid_in ? '0 : held_id_in;
      end_rsp.out_stamp   = held_invalid_in ? '0 : held_stamp_in;
      end_rsp.out_payload = held_invalid_in ? '0 : held_payload_in;
      end_rsp.list_end    = 1'b1;

      push.first  = emit_prev ? prev_rsp : end_rsp;
      push.second = end_rsp;
      if (accept) begin
         push.num = 2'({1'b0, emit_prev} + {1'b0, req_last_of_list});
      end else begin
         push.num = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_id_ff      <= held_id_in;
         held_stamp_ff   <= held_stamp_in;
         held_invalid_ff <= held_invalid_in;
         held_payload_ff <= held_payload_in;
      end
   end

   sidl_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (stat)
   );

   assign req_stall       = !stat.room_for_two;
   assign rsp_valid       = stat.not_empty;
   assign pop             = rsp_valid && !rsp_stall;
   assign rsp_has_item    = head.has_item;
   assign rsp_out_id      = head.out_id;
   assign rsp_out_stamp   = head.out_stamp;
   assign rsp_out_payload = head.out_payload;
   assign rsp_list_end    = head.list_end;

   `SIDL_ASSERT_NEXT(a_last_clears_held, clock, reset, accept && req_last_of_list, !held_valid_ff && rsp_valid, "list end did not clear held entry or queue a result")
   `SIDL_ASSERT_NEXT(a_new_run_loads, clock, reset, accept && !req_last_of_list && (!held_valid_ff || req_doc_id != held_id_ff), held_valid_ff && held_id_ff == $past(req_doc_id), "new run not loaded into held entry")
   `SIDL_ASSERT_NOW(a_two_need_room, clock, reset, push.num == 2'd2, stat.room_for_two && accept, "two results pushed without room")

endmodule

`default_nettype wire

// ----- design/sidl_out_queue.sv -----
// Result queue: takes up to two results a cycle, hands out one.
// Depends on sidl_pkg.
`default_nettype none

module sidl_out_queue #(
   parameter int DEPTH = sidl_pkg::SIDL_QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sidl_pkg::push_type push,
   input  wire logic               pop,
   output sidl_pkg::rsp_type       head,
   output sidl_pkg::qstat_type     stat
);
   import sidl_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [1:0] n);
      logic [PW:0] s;
      s = {1'b0, p} + (PW+1)'(n);
      if (s >= (PW+1)'(DEPTH)) begin
         s = s - (PW+1)'(DEPTH);
      end
      return s[PW-1:0];
   endfunction

   always_comb begin
      wr_ptr_in = ptr_add(wr_ptr_ff, push.num);
      rd_ptr_in = ptr_add(rd_ptr_ff, {1'b0, pop});
      count_in  = count_ff + CW'(push.num) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         entry_ff[ptr_add(wr_ptr_ff, 2'd1)] <= push.second;
      end
   end

   assign head              = entry_ff[rd_ptr_ff];
   assign stat.not_empty    = (count_ff != '0);
   assign stat.room_for_two = (count_ff <= CW'(DEPTH - 2));

endmodule

`default_nettype wire

// ----- verif/sidl_dedup_monitor.sv -----
`timescale 1ns / 1ps
// Watches the request and result channels of sorted_id_dedup_latest, predicts the kept entries
// and compares them with what leaves the block. Depends on sidl_pkg for the result struct.
module sidl_dedup_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_doc_id,
   input  logic [31:0] req_stamp,
   input  logic        req_is_invalid,
   input  logic [63:0] req_payload,
   input  logic        req_last_of_list,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_has_item,
   input  logic [31:0] rsp_out_id,
   input  logic [31:0] rsp_out_stamp,
   input  logic [63:0] rsp_out_payload,
   input  logic        rsp_list_end,
   output int          mismatch_count,
   output int          results_due
);

   import sidl_pkg::*;

   // entry currently kept for the open run
   logic        keep_valid;
   logic [31:0] keep_id;
   logic [31:0] keep_stamp;
   logic        keep_invalid;
   logic [63:0] keep_payload;

   rsp_type kept_entries_due[$];

   initial begin
      mismatch_count = 0;
      results_due    = 0;
      keep_valid     = 1'b0;
   end

   task automatic hold_entry(input logic [31:0] id, input logic [31:0] st, input logic inv,
                             input logic [63:0] pl);
      keep_valid   = 1'b1;
      keep_id      = id;
      keep_stamp   = st;
      keep_invalid = inv;
      keep_payload = pl;
   endtask

   // Result built from the kept entry; item fields read zero on an end-only result.
   task automatic queue_kept(input logic item, input logic closes_list);
      rsp_type r;
      r.has_item    = item;
      r.out_id      = item ? keep_id : 32'd0;
      r.out_stamp   = item ? keep_stamp : 32'd0;
      r.out_payload = item ? keep_payload : 64'd0;
      r.list_end    = closes_list;
      kept_entries_due.push_back(r);
   endtask

   task automatic predict_kept_entries(input logic [31:0] id, input logic [31:0] st,
                                       input logic inv, input logic [63:0] pl,
                                       input logic last);
      if (!keep_valid) begin
         hold_entry(id, st, inv, pl);
      end else if (id != keep_id) begin
         if (!keep_invalid)
            queue_kept(1'b1, 1'b0);
         hold_entry(id, st, inv, pl);
      end else if (keep_stamp < st) begin
         // strictly newer only; a tie keeps the earlier entry
         hold_entry(id, st, inv, pl);
      end
      if (last) begin
         queue_kept(keep_valid && !keep_invalid, 1'b1);
         keep_valid = 1'b0;
      end
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         keep_valid = 1'b0;
         kept_entries_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (kept_entries_due.size() == 0) begin
               $error("unexpected result: id %0h, stamp %0h, list_end %0b",
                      rsp_out_id, rsp_out_stamp, rsp_list_end);
               mismatch_count++;
            end else begin
               want = kept_entries_due.pop_front();
               check_field("has_item", want.has_item, rsp_has_item);
               check_field("out_id", want.out_id, rsp_out_id);
               check_field("out_stamp", want.out_stamp, rsp_out_stamp);
               check_field("out_payload", want.out_payload, rsp_out_payload);
               check_field("list_end", want.list_end, rsp_list_end);
            end
         end
         if (req_valid && !req_stall)
            predict_kept_entries(req_doc_id, req_stamp, req_is_invalid, req_payload,
                                 req_last_of_list);
      end
      results_due = kept_entries_due.size();
   end

endmodule

// ----- verif/tb_sorted_id_dedup_latest.sv -----
`timescale 1ns / 1ps
// Testbench top for sorted_id_dedup_latest: clock, reset, request stimulus and the verdict.
// Depends on sidl_pkg, the block itself and sidl_dedup_monitor.
module tb_sorted_id_dedup_latest;

   localparam int QUIET_LIMIT = 2000;
   localparam int END_SETTLE  = 20;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [31:0] req_doc_id       = '0;
   logic [31:0] req_stamp        = '0;
   logic        req_is_invalid   = 1'b0;
   logic [63:0] req_payload      = '0;
   logic        req_last_of_list = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_has_item;
   logic [31:0] rsp_out_id;
   logic [31:0] rsp_out_stamp;
   logic [63:0] rsp_out_payload;
   logic        rsp_list_end;

   int mismatch_count;
   int results_due;
   int requests_sent  = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   sorted_id_dedup_latest dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_doc_id       (req_doc_id),
      .req_stamp        (req_stamp),
      .req_is_invalid   (req_is_invalid),
      .req_payload      (req_payload),
      .req_last_of_list (req_last_of_list),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_has_item     (rsp_has_item),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_stamp    (rsp_out_stamp),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_list_end     (rsp_list_end)
   );

   sidl_dedup_monitor monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_doc_id       (req_doc_id),
      .req_stamp        (req_stamp),
      .req_is_invalid   (req_is_invalid),
      .req_payload      (req_payload),
      .req_last_of_list (req_last_of_list),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_has_item     (rsp_has_item),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_stamp    (rsp_out_stamp),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_list_end     (rsp_list_end),
      .mismatch_count   (mismatch_count),
      .results_due      (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // watchdog: cycles in which neither channel moves anything
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_entry(input logic [31:0] id, input logic [31:0] st, input logic inv,
                             input logic [63:0] pl, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_doc_id       <= id;
      req_stamp        <= st;
      req_is_invalid   <= inv;
      req_payload      <= pl;
      req_last_of_list <= last;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // hold off until every predicted result has left the block
   task automatic drain_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due != 0)
         @(negedge clock);
   endtask

   function automatic logic [31:0] pick_id(input int mode);
      case (mode)
         0:       return $urandom_range(7);
         1:       return $urandom;
         default: return $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3)
                                           : $urandom_range(3);
      endcase
   endfunction

   function automatic logic [31:0] pick_stamp(input logic [31:0] prev);
      case ($urandom_range(5))
         0:       return prev;
         1:       return prev + $urandom_range(1, 3);
         2:       return prev - 1;
         3:       return $urandom;
         4:       return 32'd0;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // one well-formed list: a few runs of equal ids, closed by an entry marked last
   task automatic send_list;
      int          mode;
      int          runs;
      int          len;
      logic [31:0] id;
      logic [31:0] st;
      mode = $urandom_range(2);
      runs = $urandom_range(1, 4);
      for (int r = 0; r < runs; r++) begin
         id  = pick_id(mode);
         st  = $urandom;
         len = $urandom_range(1, 4);
         for (int e = 0; e < len; e++) begin
            if (e != 0)
               st = pick_stamp(st);
            send_entry(id, st, $urandom_range(3) == 0, {$urandom, $urandom},
                       (r == runs - 1) && (e == len - 1));
         end
      end
   endtask

   task automatic send_noise;
      repeat ($urandom_range(1, 6))
         send_entry($urandom_range(1) ? $urandom : $urandom_range(3), $urandom,
                    1'($urandom_range(1)), {$urandom, $urandom}, $urandom_range(7) == 0);
   endtask

   initial begin
      int phase_target[3];
      phase_target = '{650, 1275, 1900};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-entry lists at the field extremes; the second is an end-only result
      send_entry(32'd0, 32'd0, 1'b0, 64'd0, 1'b1);
      send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      // run with a tie, an older and a newer stamp, closed by an id change on the last entry
      send_entry(32'd5, 32'd10, 1'b0, 64'h1111, 1'b0);
      send_entry(32'd5, 32'd10, 1'b0, 64'h2222, 1'b0);
      send_entry(32'd5, 32'd9, 1'b0, 64'h3333, 1'b0);
      send_entry(32'd5, 32'd11, 1'b0, 64'h4444, 1'b0);
      send_entry(32'd6, 32'd0, 1'b0, 64'h5555, 1'b1);
      // invalid held entry replaced by a newer one; invalid kept on a tie
      send_entry(32'd7, 32'd1, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
      send_entry(32'd7, 32'd2, 1'b0, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
      send_entry(32'd8, 32'd3, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b0);
      send_entry(32'd8, 32'd3, 1'b0, 64'hFEDC_BA98_7654_3210, 1'b0);
      send_entry(32'd9, 32'hFFFF_FFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      // id coming back after another run starts a fresh run
      send_entry(32'd1, 32'd4, 1'b0, 64'h1, 1'b0);
      send_entry(32'd2, 32'd4, 1'b0, 64'h2, 1'b0);
      send_entry(32'd1, 32'd4, 1'b0, 64'h3, 1'b1);
      // newer invalid entry wins, older last entry leaves it in place
      send_entry(32'd3, 32'd0, 1'b0, 64'h7, 1'b0);
      send_entry(32'd3, 32'd5, 1'b1, 64'h8, 1'b0);
      send_entry(32'd3, 32'd4, 1'b0, 64'h9, 1'b1);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 73 : 0;
         recv_stall_pct = (phase == 0) ? 73 : (phase == 1) ? 8 : 0;
         while (requests_sent < phase_target[phase]) begin
            if ($urandom_range(9) == 0)
               send_noise();
            else
               send_list();
         end
      end
      // close whatever run noise may have left open
      send_entry($urandom, $urandom, 1'b0, {$urandom, $urandom}, 1'b1);
      drain_results();
      repeat (END_SETTLE) @(negedge clock);

      if (mismatch_count == 0 && results_due == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
